// ===== design/quintic_velocity_profile_gen_macros.svh =====
// Assertion helpers for the velocity profile generator
`ifndef QUINTIC_VELOCITY_PROFILE_GEN_MACROS_SVH
`define QUINTIC_VELOCITY_PROFILE_GEN_MACROS_SVH
// implication checked on every rising edge outside reset
`define QVP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// consequent checked in the cycle after the antecedent
`define QVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== design/qvp_pkg.sv =====
`timescale 1ns / 1ps
package qvp_pkg;
    localparam int RATE_W_DEF = 16;
    localparam int TICK_W_DEF = 8;
    localparam int GAIN_W = 15;
    localparam int AXIS_W = 16;
    localparam int FRAC_W = 16;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_JOY  = 2'd1;
    localparam logic [1:0] OP_ODOM = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [1:0] REG_TURN_GAIN  = 2'd0;
    localparam logic [1:0] REG_SPEED_GAIN = 2'd1;
    localparam logic [1:0] REG_DURATION   = 2'd2;

    localparam logic [GAIN_W-1:0] TURN_GAIN_RST  = 15'd819;
    localparam logic [GAIN_W-1:0] SPEED_GAIN_RST = 15'd614;
    localparam int DURATION_RST = 15;

    typedef struct packed {
        logic [1:0]  op;
        logic signed [AXIS_W-1:0] axis_side;
        logic signed [AXIS_W-1:0] axis_forward;
        logic signed [AXIS_W-1:0] axis_twist;
        logic signed [RATE_W_DEF-1:0] measured_turn_rate;
        logic signed [RATE_W_DEF-1:0] measured_speed;
    } t_in_item;

    typedef struct packed {
        logic signed [RATE_W_DEF-1:0] cmd_turn_rate;
        logic signed [RATE_W_DEF-1:0] cmd_speed;
        logic profile_active;
    } t_out_item;

    // lane control from the sequencer
    typedef struct packed {
        logic load;   // latch origin and delta
        logic blend;  // evaluate with shared polynomial value
    } t_lane_ctl;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_POW  = 6'b000100,
        ST_POLY = 6'b001000,
        ST_LANE = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;
endpackage

// ===== design/qvp_lane.sv =====
`timescale 1ns / 1ps
module qvp_lane import qvp_pkg::*; #(
    parameter int RATE_W = RATE_W_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lane_ctl                i_ctl,
    input  logic signed [RATE_W-1:0] i_meas,
    input  logic signed [RATE_W-1:0] i_target,
    input  logic [FRAC_W:0]          i_poly,
    output logic signed [RATE_W-1:0] o_held
);
    localparam logic signed [RATE_W+1:0] HI = (RATE_W+2)'((64'sd1 <<< (RATE_W-1)) - 1);
    localparam logic signed [RATE_W+1:0] LO = -HI - (RATE_W+2)'(1);

    logic signed [RATE_W-1:0] r_origin;
    logic signed [RATE_W:0]   r_delta;
    logic signed [RATE_W-1:0] r_held;
    logic signed [RATE_W+FRAC_W+2:0] w_prod;
    logic signed [RATE_W+1:0] w_sum;

    // delta*P rounded, P in Q1.16 as a non-negative value
    assign w_prod = r_delta * $signed({1'b0, i_poly})
                    + (RATE_W+FRAC_W+3)'(32768);
    assign w_sum = (RATE_W+2)'(r_origin) + (RATE_W+2)'(w_prod >>> FRAC_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= '0;
            r_delta  <= '0;
            r_held   <= '0;
        end else begin
            if (i_ctl.load) begin
                r_origin <= i_meas;
                r_delta  <= (RATE_W+1)'(i_target) - (RATE_W+1)'(i_meas);
            end
            if (i_ctl.blend) begin
                if (w_sum > HI) r_held <= HI[RATE_W-1:0];
                else if (w_sum < LO) r_held <= LO[RATE_W-1:0];
                else r_held <= w_sum[RATE_W-1:0];
            end
        end
    end
    assign o_held = r_held;
endmodule

// ===== design/qvp_poly.sv =====
`timescale 1ns / 1ps
module qvp_poly import qvp_pkg::*; #(
    parameter int TICK_W = TICK_W_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TICK_W:0]   i_k,
    input  logic [TICK_W-1:0] i_len,
    output logic              o_done,
    output logic [FRAC_W:0]   o_poly
);
    // restoring divider for S = k*2^16/len, then four serial powers
    localparam int NUM_W = TICK_W + 1 + FRAC_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  r_num;
    logic [TICK_W:0]   r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic [2:0]        r_pow;
    logic              r_div_busy, r_pow_busy, r_done;
    logic [FRAC_W-1:0] r_s;
    logic [FRAC_W-1:0] r_acc;
    logic [FRAC_W+3:0] r_s3, r_s4;
    logic [TICK_W+1:0] w_trial;
    logic [2*FRAC_W-1:0] w_mul;
    logic signed [FRAC_W+8:0] w_p;
    logic [FRAC_W:0] r_poly;

    assign w_trial = {r_rem, r_num[NUM_W-1]} - {1'b0, 1'b0, i_len};
    assign w_mul = r_acc * r_s;
    assign w_p = (FRAC_W+9)'(10) * $signed({5'b0, r_s3})
               - (FRAC_W+9)'(15) * $signed({5'b0, r_s4})
               + (FRAC_W+9)'(6)  * $signed({9'b0, w_mul[2*FRAC_W-1:FRAC_W]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
            r_pow_busy <= 1'b0;
            r_done     <= 1'b0;
            r_cnt <= '0;
            r_pow <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num <= {i_k, {FRAC_W{1'b0}}};
                r_rem <= '0;
                r_cnt <= CNT_W'(NUM_W);
                r_div_busy <= 1'b1;
            end else if (r_div_busy) begin
                r_num <= {r_num[NUM_W-2:0], ~w_trial[TICK_W+1]};
                r_rem <= w_trial[TICK_W+1] ? {r_rem[TICK_W-1:0], r_num[NUM_W-1]}
                                           : w_trial[TICK_W:0];
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_div_busy <= 1'b0;
                    r_pow_busy <= 1'b1;
                    r_pow <= '0;
                end
            end else if (r_pow_busy) begin
                // len 0: quotient all ones is replaced by zero (k is 0 then)
                if (r_pow == 3'd0) begin
                    r_s   <= (i_len == '0) ? '0 : r_num[FRAC_W-1:0];
                    r_acc <= (i_len == '0) ? '0 : r_num[FRAC_W-1:0];
                    // k == len gives S = 2^16, out of Q0.16: flag as s=1
                    if (i_len != '0 && r_num[NUM_W-1:FRAC_W] != '0) begin
                        r_poly <= (FRAC_W+1)'(1) << FRAC_W;
                        r_pow_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else if (r_pow == 3'd1 || r_pow == 3'd2) begin
                    r_acc <= w_mul[2*FRAC_W-1:FRAC_W];
                    if (r_pow == 3'd2) r_s3 <= (FRAC_W+4)'(w_mul[2*FRAC_W-1:FRAC_W]);
                end else if (r_pow == 3'd3) begin
                    r_acc <= w_mul[2*FRAC_W-1:FRAC_W];
                    r_s4  <= (FRAC_W+4)'(w_mul[2*FRAC_W-1:FRAC_W]);
                end else begin
                    if (w_p < 0) r_poly <= '0;
                    else if (w_p > (FRAC_W+9)'(65536)) r_poly <= (FRAC_W+1)'(65536);
                    else r_poly <= w_p[FRAC_W:0];
                    r_pow_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_pow <= r_pow + 3'd1;
            end
        end
    end
    assign o_done = r_done;
    assign o_poly = r_poly;
endmodule

// ===== design/quintic_velocity_profile_gen.sv =====
`timescale 1ns / 1ps
// Joystick, odometry and undefined-op items are taken in IDLE and give no result.
// An evaluating tick runs a 25-step restoring divider for s, five
// power/polynomial steps, one blend and one output step before its result.
// The last tick of a profile skips the powers; latch and expired ticks
// answer the next cycle. The next item is taken the cycle after the result leaves.
// Synchronous active-low reset restores register defaults and clears state.
`include "quintic_velocity_profile_gen_macros.svh"
module quintic_velocity_profile_gen import qvp_pkg::*; #(
    parameter int TICK_COUNT_WIDTH = TICK_W_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    // rate width is fixed by the item structs in the package
    localparam int RW = RATE_W_DEF;
    localparam int TW = TICK_COUNT_WIDTH;
    localparam logic signed [RW+1:0] HI = (RW+2)'((64'sd1 <<< (RW-1)) - 1);
    localparam logic signed [RW+1:0] LO = -HI - (RW+2)'(1);

    // configuration
    logic [GAIN_W-1:0] r_turn_gain, r_speed_gain;
    logic [TW-1:0]     r_duration;
    logic              w_cfg_wr;
    logic [1:0]        w_reg;
    assign pready = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_reg = paddr[3:2];

    always_comb begin
        prdata = '0;
        unique case (w_reg)
            REG_TURN_GAIN:  prdata = 32'(r_turn_gain);
            REG_SPEED_GAIN: prdata = 32'(r_speed_gain);
            REG_DURATION:   prdata = 32'(r_duration);
            default:        prdata = '0;
        endcase
    end

    // state
    t_state r_state;
    logic   r_pending;
    logic [TW:0]   r_elapsed;
    logic [TW-1:0] r_len;
    logic signed [RW-1:0] r_tgt_turn, r_tgt_speed, r_meas_turn, r_meas_speed;
    logic   r_ovalid, r_active;

    logic w_acc;
    assign o_stall = (r_state != ST_IDLE) || r_ovalid;
    assign w_acc = i_valid && !o_stall;

    // joystick scaling: side and twist share one turn product; forward is scaled alone
    logic signed [AXIS_W+GAIN_W+1:0] w_pt, w_ps;
    logic both_zero;
    logic signed [AXIS_W-1:0] w_turn_axis;
    assign both_zero = (i_item.axis_side == '0) && (i_item.axis_forward == '0);
    assign w_turn_axis = both_zero ? i_item.axis_twist : i_item.axis_side;
    assign w_pt = ($signed({1'b0, r_turn_gain}) * w_turn_axis + 16384) >>> 15;
    assign w_ps = -(($signed({1'b0, r_speed_gain}) * i_item.axis_forward + 16384) >>> 15);

    function automatic logic signed [RW-1:0] sat_r(input logic signed [AXIS_W+GAIN_W+1:0] x);
        if (x > (AXIS_W+GAIN_W+2)'(HI)) return HI[RW-1:0];
        else if (x < (AXIS_W+GAIN_W+2)'(LO)) return LO[RW-1:0];
        else return x[RW-1:0];
    endfunction

    // tick sequencing
    t_lane_ctl w_ctl;
    logic w_poly_start, w_poly_done;
    logic [FRAC_W:0] w_poly;
    logic signed [RW-1:0] w_held_turn, w_held_speed;

    assign w_poly_start = w_acc && i_item.op == OP_TICK && !r_pending
                          && r_elapsed <= (TW+1)'(r_len);
    assign w_ctl.load  = w_acc && i_item.op == OP_TICK && r_pending;
    assign w_ctl.blend = (r_state == ST_DIV) && w_poly_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_gain  <= TURN_GAIN_RST;
            r_speed_gain <= SPEED_GAIN_RST;
            r_duration   <= TW'(DURATION_RST);
            r_state   <= ST_IDLE;
            r_pending <= 1'b0;
            r_elapsed <= '0;
            r_len     <= '0;
            r_tgt_turn <= '0; r_tgt_speed <= '0;
            r_meas_turn <= '0; r_meas_speed <= '0;
            r_ovalid <= 1'b0;
            r_active <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                unique case (w_reg)
                    REG_TURN_GAIN:  r_turn_gain  <= pwdata[GAIN_W-1:0];
                    REG_SPEED_GAIN: r_speed_gain <= pwdata[GAIN_W-1:0];
                    REG_DURATION:   r_duration   <= pwdata[TW-1:0];
                    default: ;
                endcase
            end
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        unique case (i_item.op)
                            OP_JOY: begin
                                r_tgt_turn  <= sat_r(w_pt);
                                r_tgt_speed <= both_zero ? '0 : sat_r(w_ps);
                                r_pending   <= 1'b1;
                            end
                            OP_ODOM: begin
                                r_meas_turn  <= i_item.measured_turn_rate[RW-1:0];
                                r_meas_speed <= i_item.measured_speed[RW-1:0];
                            end
                            OP_TICK: begin
                                if (r_pending) begin
                                    r_pending <= 1'b0;
                                    r_len     <= r_duration;
                                    r_elapsed <= (TW+1)'(1);
                                    r_active  <= 1'b0;
                                    r_ovalid  <= 1'b1;
                                end else if (w_poly_start) begin
                                    r_state <= ST_DIV;
                                end else begin
                                    r_pending <= 1'b1;
                                    r_active  <= 1'b0;
                                    r_ovalid  <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_DIV: begin
                    if (w_poly_done) r_state <= ST_OUT;
                end
                ST_OUT: begin
                    r_elapsed <= r_elapsed + (TW+1)'(1);
                    r_active  <= 1'b1;
                    r_ovalid  <= 1'b1;
                    r_state   <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    qvp_poly #(.TICK_W(TW)) u_poly (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_poly_start),
        .i_k(r_elapsed), .i_len(r_len), .o_done(w_poly_done), .o_poly(w_poly)
    );

    qvp_lane #(.RATE_W(RW)) u_lane_turn (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_meas(r_meas_turn),
        .i_target(r_tgt_turn), .i_poly(w_poly), .o_held(w_held_turn)
    );
    qvp_lane #(.RATE_W(RW)) u_lane_speed (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl), .i_meas(r_meas_speed),
        .i_target(r_tgt_speed), .i_poly(w_poly), .o_held(w_held_speed)
    );

    // merge: both lanes into one result item
    assign o_valid = r_ovalid;
    assign o_item.cmd_turn_rate  = RATE_W_DEF'(w_held_turn);
    assign o_item.cmd_speed      = RATE_W_DEF'(w_held_speed);
    assign o_item.profile_active = r_active;

    `QVP_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != ST_IDLE, o_stall,
        "item accepted while a tick is in progress")
    `QVP_ASSERT_NEXT(a_out_done, i_clk, i_rst_n, r_state == ST_OUT, o_valid,
        "finished tick gave no result")
    `QVP_ASSERT_IMP(a_active_len, i_clk, i_rst_n, o_valid && o_item.profile_active,
        r_elapsed <= (TW+1)'(r_len) + (TW+1)'(1), "active result past profile end")
endmodule
